>>> src/odks_pkg.sv
// Shared types and constants for the opaque draw key sorter.
package odks_pkg;

    localparam int KEY_FIELD_W = 32;
    localparam int HANDLE_PORT_W = 16;
    localparam int TDATA_W = 3 * KEY_FIELD_W + HANDLE_PORT_W;

    // Sort key; material sits in the top bits so a packed compare is lexicographic
    typedef struct packed {
        logic [KEY_FIELD_W-1:0] material;
        logic [KEY_FIELD_W-1:0] mesh;
        logic [KEY_FIELD_W-1:0] object;
    } key_t;

    // Classification the front end attaches to each queued record
    typedef struct packed {
        logic drop;
        logic last;
    } rec_flags_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } back_state_t;

endpackage

>>> src/odks_front.sv
// Front end: accepts records, tracks batch fill and marks dropped records.
module odks_front import odks_pkg::*; #(
    parameter int MAX_DRAWS = 64,
    parameter int HANDLE_W  = 16,
    localparam int CNT_W    = $clog2(MAX_DRAWS + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  key_t                     in_key,
    input  logic [HANDLE_PORT_W-1:0] in_hnd,
    input  logic                     in_last,
    output logic                     q_push,
    input  logic                     q_full,
    output key_t                     q_key,
    output logic [HANDLE_W-1:0]      q_hnd,
    output rec_flags_t               q_flags
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             full_batch;

    // Records are forwarded straight into the queue
    assign in_ready   = !q_full;
    assign q_push     = in_valid && in_ready;
    assign full_batch = (cnt_reg == CNT_W'(MAX_DRAWS));
    assign q_key      = in_key;
    assign q_hnd      = in_hnd[HANDLE_W-1:0];

    always_comb begin
        q_flags.drop = full_batch;
        q_flags.last = in_last;
    end

    // Per-batch record count, restarts after the closing record
    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (in_last) begin
                cnt_next = '0;
            end else if (!full_batch) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> src/odks_fifo.sv
// Two-entry queue between the front end and the sort engine.
module odks_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/odks_back.sv
// Sort engine: insertion chain of cells that fills in order and drains from cell 0.
module odks_back import odks_pkg::*; #(
    parameter int MAX_DRAWS = 64,
    parameter int HANDLE_W  = 16,
    localparam int CNT_W    = $clog2(MAX_DRAWS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  key_t                q_key,
    input  logic [HANDLE_W-1:0] q_hnd,
    input  rec_flags_t          q_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output key_t                out_key,
    output logic [HANDLE_W-1:0] out_hnd,
    output logic                out_last,
    output logic                out_ovf
);

    key_t                key_reg [MAX_DRAWS];
    key_t                key_next [MAX_DRAWS];
    logic [HANDLE_W-1:0] hnd_reg [MAX_DRAWS];
    logic [HANDLE_W-1:0] hnd_next [MAX_DRAWS];
    logic [MAX_DRAWS-1:0] lt;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    back_state_t         state_reg, state_next;
    logic                ovalid_reg, ovalid_next;
    key_t                okey_reg, okey_next;
    logic [HANDLE_W-1:0] ohnd_reg, ohnd_next;
    logic                olast_reg, olast_next;
    logic                oovf_reg, oovf_next;
    logic                load;

    // New record goes ahead of cell i when strictly smaller or cell i is empty
    always_comb begin
        for (int i = 0; i < MAX_DRAWS; i++) begin
            lt[i] = (CNT_W'(i) >= cnt_reg) || (q_key < key_reg[i]);
        end
    end

    assign load = !ovalid_reg || out_ready;

    // Next state, chain update and output register load
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        ovalid_next = ovalid_reg && !out_ready;
        okey_next   = okey_reg;
        ohnd_next   = ohnd_reg;
        olast_next  = olast_reg;
        oovf_next   = oovf_reg;
        q_ready     = 1'b0;
        for (int i = 0; i < MAX_DRAWS; i++) begin
            key_next[i] = key_reg[i];
            hnd_next[i] = hnd_reg[i];
        end
        unique case (state_reg)
            ST_FILL: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    ovf_next = ovf_reg || q_flags.drop;
                    if (!q_flags.drop) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (lt[0]) begin
                            key_next[0] = q_key;
                            hnd_next[0] = q_hnd;
                        end
                        for (int i = 1; i < MAX_DRAWS; i++) begin
                            if (lt[i-1]) begin
                                key_next[i] = key_reg[i-1];
                                hnd_next[i] = hnd_reg[i-1];
                            end else if (lt[i]) begin
                                key_next[i] = q_key;
                                hnd_next[i] = q_hnd;
                            end
                        end
                    end
                    if (q_flags.last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_FILL;
                    ovf_next   = 1'b0;
                end else if (load) begin
                    ovalid_next = 1'b1;
                    okey_next   = key_reg[0];
                    ohnd_next   = hnd_reg[0];
                    olast_next  = (cnt_reg == CNT_W'(1));
                    oovf_next   = ovf_reg;
                    cnt_next    = cnt_reg - CNT_W'(1);
                    for (int i = 0; i < MAX_DRAWS - 1; i++) begin
                        key_next[i] = key_reg[i+1];
                        hnd_next[i] = hnd_reg[i+1];
                    end
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_FILL;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Cells and output payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_DRAWS; i++) begin
            key_reg[i] <= key_next[i];
            hnd_reg[i] <= hnd_next[i];
        end
        okey_reg  <= okey_next;
        ohnd_reg  <= ohnd_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    assign out_valid = ovalid_reg;
    assign out_key   = okey_reg;
    assign out_hnd   = ohnd_reg;
    assign out_last  = olast_reg;
    assign out_ovf   = oovf_reg;

endmodule

>>> src/opaque_draw_key_sorter.sv
// Top level of the opaque draw key sorter: stream ports, front end, queue, sort engine.
// Fill: one record per cycle while the queue has room; records pass the queue into the chain.
// Once the closing record has passed through the queue into the chain, the sorted run leaves
// via the output register at one record per cycle while m_tready is high, paced by cell 0.
// Input stalls while a run drains once the queue is full.
// Reset (aresetn low, synchronous) empties the queue, batch counts and output; no clearing pass.
module opaque_draw_key_sorter import odks_pkg::*; #(
    parameter int MAX_DRAWS   = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // material_id[31:0], mesh_id[63:32], object_id[95:64], draw_handle[111:96]
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // sorted_material[31:0], sorted_mesh[63:32], sorted_object[95:64],
    // sorted_handle[111:96]
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    // overflowed[0]
    output logic               m_tuser
);

    localparam int HANDLE_W = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
    localparam int Q_W      = $bits(rec_flags_t) + HANDLE_W + $bits(key_t);

    key_t                 in_key;
    key_t                 fq_key, bq_key, out_key;
    logic [HANDLE_W-1:0]  fq_hnd, bq_hnd, out_hnd;
    rec_flags_t           fq_flags, bq_flags;
    logic                 q_push, q_full, q_valid, q_ready;
    logic [Q_W-1:0]       q_wdata, q_rdata;
    logic [HANDLE_PORT_W-1:0] hnd16;

    always_comb begin
        in_key.material = s_tdata[KEY_FIELD_W-1:0];
        in_key.mesh     = s_tdata[2*KEY_FIELD_W-1:KEY_FIELD_W];
        in_key.object   = s_tdata[3*KEY_FIELD_W-1:2*KEY_FIELD_W];
    end

    odks_front #(
        .MAX_DRAWS (MAX_DRAWS),
        .HANDLE_W  (HANDLE_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_key   (in_key),
        .in_hnd   (s_tdata[TDATA_W-1:3*KEY_FIELD_W]),
        .in_last  (s_tlast),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_key    (fq_key),
        .q_hnd    (fq_hnd),
        .q_flags  (fq_flags)
    );

    assign q_wdata = {fq_flags, fq_hnd, fq_key};

    odks_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_ready),
        .pop_data  (q_rdata)
    );

    assign {bq_flags, bq_hnd, bq_key} = q_rdata;

    odks_back #(
        .MAX_DRAWS (MAX_DRAWS),
        .HANDLE_W  (HANDLE_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_key     (bq_key),
        .q_hnd     (bq_hnd),
        .q_flags   (bq_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_key   (out_key),
        .out_hnd   (out_hnd),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

    // Zero-extend the stored handle to the port field
    always_comb begin
        hnd16               = '0;
        hnd16[HANDLE_W-1:0] = out_hnd;
    end

    assign m_tdata = {hnd16, out_key.object, out_key.mesh, out_key.material};

endmodule

>>> src/odks_checker.sv
// Port-level checks for the opaque draw key sorter, bound to the top level.
module odks_checker import odks_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    logic [3*KEY_FIELD_W-1:0] cur_key;
    logic [3*KEY_FIELD_W-1:0] prev_key_reg;
    logic                     prev_ovf_reg;
    logic                     in_run_reg;
    logic                     xfer;

    assign xfer    = m_tvalid && m_tready;
    assign cur_key = {m_tdata[KEY_FIELD_W-1:0], m_tdata[2*KEY_FIELD_W-1:KEY_FIELD_W],
                      m_tdata[3*KEY_FIELD_W-1:2*KEY_FIELD_W]};

    // Remember the previous transfer of the current run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
        end else if (xfer) begin
            in_run_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            prev_key_reg <= cur_key;
            prev_ovf_reg <= m_tuser;
        end
    end

    // No result is offered right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Keys within a run never descend
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && in_run_reg |-> !(cur_key < prev_key_reg))
        else $error("run out of key order");

    // Overflow flag is the same for every result of a run
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && in_run_reg |-> (m_tuser == prev_ovf_reg))
        else $error("overflow flag changed within run");

endmodule

bind opaque_draw_key_sorter odks_checker u_odks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
